@@ src/grpm_pkg.sv @@
// shared constants, register codes and lane control type for the gain and meter block
package grpm_pkg;

  // fixed field widths
  localparam int unsigned IN_CH           = 2;
  localparam int unsigned DEF_CHANNELS    = 2;
  localparam int unsigned DEF_SAMPLE_BITS = 24;
  localparam int unsigned GAIN_W          = 24;
  localparam int unsigned INC_W           = 25;
  localparam int unsigned STEPS_W         = 14;
  localparam int unsigned ALPHA_W         = 16;
  localparam int unsigned MS_W            = 32;
  localparam int unsigned GAIN_FRAC       = 20;
  localparam int unsigned CFG_IDX_W       = 3;
  localparam int unsigned CFG_DATA_W      = 24;

  // register reset values
  localparam logic [GAIN_W-1:0]  UNITY_GAIN     = 24'd1048576;
  localparam logic [STEPS_W-1:0] RAMP_STEPS_RST = 14'd960;
  localparam logic [ALPHA_W-1:0] ALPHA_RST      = 16'd65396;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_TARGET  = 3'd0,
    REG_RAMP_STEPS   = 3'd1,
    REG_ALPHA_RMS    = 3'd2,
    REG_PHASE_INVERT = 3'd3,
    REG_BYPASS       = 3'd4
  } cfg_idx_e;

  // per-stage strobes from the sequencer to every lane
  typedef struct packed {
    logic load;
    logic clear_peak;
    logic mul;
    logic sat;
    logic sqr;
    logic msa;
    logic msb;
    logic commit;
  } lane_ctrl_t;

endpackage

@@ src/grpm_div.sv @@
// restoring divider for the gain ramp increment, one quotient bit per cycle
module grpm_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic                               kill_i,
  input  logic [grpm_pkg::GAIN_W-1:0]        dividend_i,
  input  logic [grpm_pkg::STEPS_W-1:0]       divisor_i,
  input  logic                               negate_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic signed [grpm_pkg::INC_W-1:0]  quotient_o
);
  import grpm_pkg::*;

  localparam int unsigned CNT_W = $clog2(GAIN_W + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [GAIN_W-1:0]    quo_q, quo_d;
  logic [STEPS_W-1:0]   rem_q, rem_d;
  logic [STEPS_W-1:0]   div_q, div_d;
  logic                 neg_q, neg_d;
  logic [STEPS_W:0]     trial;
  logic [STEPS_W:0]     trial_sub;
  logic                 fits;
  logic signed [INC_W-1:0] quo_ext;

  // one trial subtraction per cycle
  assign trial     = {rem_q, quo_q[GAIN_W-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign fits      = (trial >= {1'b0, div_q});

  // step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (kill_i) begin
      busy_d = 1'b0;
    end else if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(GAIN_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = negate_i;
    end else if (busy_q) begin
      quo_d = {quo_q[GAIN_W-2:0], fits};
      rem_d = fits ? trial_sub[STEPS_W-1:0] : trial[STEPS_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  // signed increment, truncated toward zero
  assign quo_ext    = $signed({1'b0, quo_q});
  assign quotient_o = neg_q ? -quo_ext : quo_ext;
  assign busy_o     = busy_q | done_q;
  assign done_o     = done_q;

endmodule

@@ src/grpm_lane.sv @@
// one channel lane: gain, rounding and saturation, peak hold and mean-square average
module grpm_lane #(
  parameter int unsigned SAMPLE_BITS = grpm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  grpm_pkg::lane_ctrl_t                ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic signed [grpm_pkg::INC_W-1:0]   gain_i,
  input  logic                                bypass_i,
  input  logic [grpm_pkg::ALPHA_W-1:0]        alpha_i,
  output logic [SAMPLE_BITS-1:0]              y_o,
  output logic [SAMPLE_BITS-1:0]              peak_o,
  output logic [grpm_pkg::MS_W-1:0]           ms_o
);
  import grpm_pkg::*;

  localparam int unsigned PROD_W   = SAMPLE_BITS + INC_W;
  localparam int unsigned SQ_W     = 2 * SAMPLE_BITS;
  localparam int unsigned SQX_W    = SQ_W + 2;
  localparam int unsigned SQ_SHIFT = SQ_W - 32;
  localparam int unsigned TA_W     = ALPHA_W + MS_W;
  localparam int unsigned TB_W     = ALPHA_W + 1 + MS_W;
  localparam logic signed [PROD_W:0] RND = (PROD_W + 1)'(1) <<< (GAIN_FRAC - 1);
  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [PROD_W-1:0]      prod_full;
  logic signed [PROD_W-1:0]      prod_q;
  logic signed [PROD_W:0]        rnd;
  logic signed [PROD_W:0]        shifted;
  logic [PROD_W-SAMPLE_BITS+1:0] top_bits;
  logic signed [SAMPLE_BITS-1:0] gained;
  logic signed [SAMPLE_BITS-1:0] y_q;
  logic [SAMPLE_BITS-1:0]        mag;
  logic [SAMPLE_BITS-1:0]        peak_base;
  logic [SAMPLE_BITS-1:0]        peak_q;
  logic [SQ_W-1:0]               sq_q;
  logic [SQX_W-1:0]              sq_ext;
  logic [MS_W-1:0]               sq32;
  logic [ALPHA_W:0]              one_minus;
  logic [TA_W-1:0]               ta_q;
  logic [TB_W-1:0]               tb_q;
  logic [TB_W-1:0]               ms_sum;
  logic [MS_W-1:0]               ms_q;

  // gain product
  assign prod_full = smp_q * gain_i;

  // round to nearest, drop the gain fraction, saturate
  assign rnd      = {prod_q[PROD_W-1], prod_q} + RND;
  assign shifted  = rnd >>> GAIN_FRAC;
  assign top_bits = shifted[PROD_W:SAMPLE_BITS-1];
  always_comb begin
    if ((&top_bits) || !(|top_bits)) begin
      gained = shifted[SAMPLE_BITS-1:0];
    end else begin
      gained = shifted[PROD_W] ? S_MIN : S_MAX;
    end
  end

  // magnitude and peak hold
  assign mag       = y_q[SAMPLE_BITS-1] ? SAMPLE_BITS'(-y_q) : SAMPLE_BITS'(y_q);
  assign peak_base = ctrl_i.clear_peak ? '0 : peak_q;

  // square scaled to q0.32 with saturation
  assign sq_ext    = {sq_q, 2'b00} >> SQ_SHIFT;
  assign sq32      = (|sq_ext[SQX_W-1:MS_W]) ? '1 : sq_ext[MS_W-1:0];
  assign one_minus = (ALPHA_W + 1)'(1 << ALPHA_W) - {1'b0, alpha_i};

  // one-pole average
  assign ms_sum = {1'b0, ta_q} + tb_q;
  assign ms_o   = ms_sum[TA_W-1:ALPHA_W];

  // working registers, one stage per strobe
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      smp_q <= sample_i;
    end
    if (ctrl_i.mul) begin
      prod_q <= prod_full;
    end
    if (ctrl_i.sat) begin
      y_q <= bypass_i ? smp_q : gained;
    end
    if (ctrl_i.sqr) begin
      sq_q <= SQ_W'(mag) * SQ_W'(mag);
    end
    if (ctrl_i.msa) begin
      ta_q <= TA_W'(alpha_i) * TA_W'(ms_q);
    end
    if (ctrl_i.msb) begin
      tb_q <= TB_W'(one_minus) * TB_W'(sq32);
    end
  end

  // metering state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      ms_q   <= '0;
    end else begin
      if (ctrl_i.sqr) begin
        peak_q <= (mag > peak_base) ? mag : peak_base;
      end
      if (ctrl_i.commit) begin
        ms_q <= ms_o;
      end
    end
  end

  assign y_o    = y_q;
  assign peak_o = peak_q;

endmodule

@@ src/gain_ramp_peak_rms_meter.sv @@
// top level: stereo gain ramp with peak and mean-square meters
//
//   port group     direction  beat accepted when
//   in  (samples)  in         in_valid_i  & in_ready_o
//   out (results)  out        out_valid_o & out_ready_i
//   cfg (writes)   in         cfg_we_i, every edge it is high
//
// a frame passes from acceptance to its result through one sequencer
// that steps all channel lanes together (ramp, multiply, saturate, square, two
// average products, commit); the next frame is taken once the sequencer is idle
// and no divide is running, so only one frame is in flight at a time
// writing a new gain target with a nonzero ramp length runs a 24-step bit-serial
// divide for the ramp step, and frames are held off until the increment is loaded
// a result waiting on out_ready_i stalls only the commit step; reset returns the
// configuration and metering registers to their defaults, unity gain and empty meters, with no sweep
module gain_ramp_peak_rms_meter #(
  parameter int unsigned CHANNELS    = grpm_pkg::DEF_CHANNELS,
  parameter int unsigned SAMPLE_BITS = grpm_pkg::DEF_SAMPLE_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [grpm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [grpm_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]        sample_left_i,
  input  logic signed [SAMPLE_BITS-1:0]        sample_right_i,
  input  logic                                 block_start_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]        out_left_o,
  output logic signed [SAMPLE_BITS-1:0]        out_right_o,
  output logic [SAMPLE_BITS-1:0]               peak_left_o,
  output logic [SAMPLE_BITS-1:0]               peak_right_o,
  output logic [grpm_pkg::MS_W-1:0]            mean_square_left_o,
  output logic [grpm_pkg::MS_W-1:0]            mean_square_right_o
);
  import grpm_pkg::*;

  localparam int unsigned LANES = (CHANNELS < IN_CH) ? CHANNELS : IN_CH;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_RAMP = 8'b0000_0010,
    ST_MUL  = 8'b0000_0100,
    ST_SAT  = 8'b0000_1000,
    ST_SQR  = 8'b0001_0000,
    ST_MSA  = 8'b0010_0000,
    ST_MSB  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration and ramp state
  logic [GAIN_W-1:0]       target_q, target_d;
  logic [STEPS_W-1:0]      steps_q, steps_d;
  logic [ALPHA_W-1:0]      alpha_q, alpha_d;
  logic                    phase_q, phase_d;
  logic                    bypass_q, bypass_d;
  logic [GAIN_W-1:0]       gain_q, gain_d;
  logic signed [INC_W-1:0] inc_q, inc_d;
  logic [STEPS_W-1:0]      rem_q, rem_d;
  logic [STEPS_W-1:0]      rem_dec;
  logic signed [INC_W:0]   gain_sum;
  logic [GAIN_W-1:0]       gain_clamped;
  logic signed [INC_W-1:0] applied_gain;
  logic signed [INC_W-1:0] cfg_diff;
  logic [GAIN_W-1:0]       cfg_mag;

  // divider hookup
  logic                    div_start;
  logic                    div_kill;
  logic                    div_busy;
  logic                    div_done;
  logic signed [INC_W-1:0] div_quo;

  // frame handshake and sequencing
  logic                    accept;
  logic                    commit;
  logic                    blk_q;
  lane_ctrl_t              ctrl;

  // lane results and output registers
  logic [SAMPLE_BITS-1:0]  smp_in  [IN_CH];
  logic [SAMPLE_BITS-1:0]  lane_y  [IN_CH];
  logic [SAMPLE_BITS-1:0]  lane_pk [IN_CH];
  logic [MS_W-1:0]         lane_ms [IN_CH];
  logic [SAMPLE_BITS-1:0]  out_y_q  [IN_CH];
  logic [SAMPLE_BITS-1:0]  out_pk_q [IN_CH];
  logic [MS_W-1:0]         out_ms_q [IN_CH];
  logic                    out_valid_q;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE) & ~div_busy;
  assign commit     = (state_q == ST_DONE) & (~out_valid_q | out_ready_i);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_RAMP;
      ST_RAMP: state_d = ST_MUL;
      ST_MUL:  state_d = ST_SAT;
      ST_SAT:  state_d = ST_SQR;
      ST_SQR:  state_d = ST_MSA;
      ST_MSA:  state_d = ST_MSB;
      ST_MSB:  state_d = ST_DONE;
      ST_DONE: if (commit) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // lane strobes
  always_comb begin
    ctrl            = '0;
    ctrl.load       = accept;
    ctrl.clear_peak = blk_q;
    ctrl.mul        = (state_q == ST_MUL);
    ctrl.sat        = (state_q == ST_SAT);
    ctrl.sqr        = (state_q == ST_SQR);
    ctrl.msa        = (state_q == ST_MSA);
    ctrl.msb        = (state_q == ST_MSB);
    ctrl.commit     = commit;
  end

  // ramp step with clamp to the gain range
  assign rem_dec  = rem_q - 1'b1;
  assign gain_sum = $signed({2'b00, gain_q}) + $signed({inc_q[INC_W-1], inc_q});
  always_comb begin
    if (gain_sum[INC_W]) begin
      gain_clamped = '0;
    end else if (gain_sum[INC_W-1]) begin
      gain_clamped = '1;
    end else begin
      gain_clamped = gain_sum[GAIN_W-1:0];
    end
  end

  // distance from current gain to a newly written target
  assign cfg_diff = $signed({1'b0, cfg_wdata_i[GAIN_W-1:0]}) - $signed({1'b0, gain_q});
  assign cfg_mag  = cfg_diff[INC_W-1] ? GAIN_W'(-cfg_diff) : GAIN_W'(cfg_diff);

  // register writes, ramp advance and increment load
  always_comb begin
    target_d  = target_q;
    steps_d   = steps_q;
    alpha_d   = alpha_q;
    phase_d   = phase_q;
    bypass_d  = bypass_q;
    gain_d    = gain_q;
    inc_d     = inc_q;
    rem_d     = rem_q;
    div_start = 1'b0;
    div_kill  = 1'b0;
    if (div_done) begin
      inc_d = div_quo;
    end
    if ((state_q == ST_RAMP) && !bypass_q && (rem_q != '0)) begin
      rem_d  = rem_dec;
      gain_d = (rem_dec != '0) ? gain_clamped : target_q;
    end
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_TARGET: begin
          if (cfg_wdata_i[GAIN_W-1:0] != target_q) begin
            target_d = cfg_wdata_i[GAIN_W-1:0];
            if (steps_q == '0) begin
              gain_d   = cfg_wdata_i[GAIN_W-1:0];
              inc_d    = '0;
              rem_d    = '0;
              div_kill = 1'b1;
            end else begin
              rem_d     = steps_q;
              div_start = 1'b1;
            end
          end
        end
        REG_RAMP_STEPS:   steps_d  = cfg_wdata_i[STEPS_W-1:0];
        REG_ALPHA_RMS:    alpha_d  = cfg_wdata_i[ALPHA_W-1:0];
        REG_PHASE_INVERT: phase_d  = cfg_wdata_i[0];
        REG_BYPASS:       bypass_d = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      target_q    <= UNITY_GAIN;
      steps_q     <= RAMP_STEPS_RST;
      alpha_q     <= ALPHA_RST;
      phase_q     <= 1'b0;
      bypass_q    <= 1'b0;
      gain_q      <= UNITY_GAIN;
      inc_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      target_q <= target_d;
      steps_q  <= steps_d;
      alpha_q  <= alpha_d;
      phase_q  <= phase_d;
      bypass_q <= bypass_d;
      gain_q   <= gain_d;
      inc_q    <= inc_d;
      rem_q    <= rem_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // block start flag travels with the frame
  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q <= block_start_i;
    end
  end

  // ramp increment divider
  grpm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .kill_i     (div_kill),
    .dividend_i (cfg_mag),
    .divisor_i  (steps_q),
    .negate_i   (cfg_diff[INC_W-1]),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // signed gain shared by all lanes
  assign applied_gain = phase_q ? -$signed({1'b0, gain_q}) : $signed({1'b0, gain_q});

  assign smp_in[0] = sample_left_i;
  assign smp_in[1] = sample_right_i;

  // channel lanes, absent channels read as zero
  for (genvar i = 0; i < IN_CH; i++) begin : g_lane
    if (i < LANES) begin : g_on
      grpm_lane #(
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (ctrl),
        .sample_i ($signed(smp_in[i])),
        .gain_i   (applied_gain),
        .bypass_i (bypass_q),
        .alpha_i  (alpha_q),
        .y_o      (lane_y[i]),
        .peak_o   (lane_pk[i]),
        .ms_o     (lane_ms[i])
      );
    end else begin : g_off
      assign lane_y[i]  = '0;
      assign lane_pk[i] = '0;
      assign lane_ms[i] = '0;
    end
  end

  // result register, loaded when the frame commits
  always_ff @(posedge clk_i) begin
    if (commit) begin
      for (int c = 0; c < IN_CH; c++) begin
        out_y_q[c]  <= lane_y[c];
        out_pk_q[c] <= lane_pk[c];
        out_ms_q[c] <= lane_ms[c];
      end
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_left_o          = $signed(out_y_q[0]);
  assign out_right_o         = $signed(out_y_q[1]);
  assign peak_left_o         = out_pk_q[0];
  assign peak_right_o        = out_pk_q[1];
  assign mean_square_left_o  = out_ms_q[0];
  assign mean_square_right_o = out_ms_q[1];

endmodule

@@ src/grpm_checker.sv @@
// port-level checks for the gain and meter block, bound to the top level
module grpm_checker #(
  parameter int unsigned SAMPLE_BITS = grpm_pkg::DEF_SAMPLE_BITS
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic [SAMPLE_BITS-1:0]          out_left_o,
  input logic [SAMPLE_BITS-1:0]          out_right_o,
  input logic [SAMPLE_BITS-1:0]          peak_left_o,
  input logic [SAMPLE_BITS-1:0]          peak_right_o
);

  logic [SAMPLE_BITS-1:0] mag_left;
  logic [SAMPLE_BITS-1:0] mag_right;

  // magnitude of the shown samples
  assign mag_left  = out_left_o[SAMPLE_BITS-1] ? (~out_left_o + 1'b1) : out_left_o;
  assign mag_right = out_right_o[SAMPLE_BITS-1] ? (~out_right_o + 1'b1) : out_right_o;

  // a waiting result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_left_o))
    else $error("result beat dropped or changed while stalled");

  // the peak covers the sample it comes with
  a_peak_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> peak_left_o >= mag_left)
    else $error("left peak below left sample magnitude");

  a_peak_right: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> peak_right_o >= mag_right)
    else $error("right peak below right sample magnitude");

  // one frame at a time through the sequencer
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("frame taken while the previous one is in flight");

endmodule

bind gain_ramp_peak_rms_meter grpm_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_grpm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_left_o   (out_left_o),
  .out_right_o  (out_right_o),
  .peak_left_o  (peak_left_o),
  .peak_right_o (peak_right_o)
);

@@ dv/gain_ramp_peak_rms_meter_test.sv @@
// self-checking testbench for the stereo gain ramp with peak and mean-square meters
module gain_ramp_peak_rms_meter_test;
  timeunit 1ns;
  timeprecision 1ps;
  import grpm_pkg::*;

  localparam int unsigned SW          = DEF_SAMPLE_BITS;
  localparam int unsigned SQ_SHIFT    = 2 * SW - 34;
  localparam int unsigned MAX_GAP     = 18;
  localparam int unsigned MAX_PRINTED = 30;
  localparam logic [SW-1:0]     FS_NEG   = {1'b1, {(SW-1){1'b0}}};
  localparam logic [SW-1:0]     FS_POS   = {1'b0, {(SW-1){1'b1}}};
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  // indexes past the last register, which the block must ignore
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [SW-1:0]   left_out;
    logic [SW-1:0]   right_out;
    logic [SW-1:0]   left_peak;
    logic [SW-1:0]   right_peak;
    logic [MS_W-1:0] left_msq;
    logic [MS_W-1:0] right_msq;
  } meter_frame_t;

  // block ports, all inputs known from time zero
  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i      = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic signed [SW-1:0]  sample_left_i  = '0;
  logic signed [SW-1:0]  sample_right_i = '0;
  logic                  block_start_i  = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic signed [SW-1:0]  out_left_o;
  logic signed [SW-1:0]  out_right_o;
  logic [SW-1:0]         peak_left_o;
  logic [SW-1:0]         peak_right_o;
  logic [MS_W-1:0]       mean_square_left_o;
  logic [MS_W-1:0]       mean_square_right_o;

  // shadow registers and gain / meter state of the predictor
  logic [GAIN_W-1:0]       gain_tgt  = UNITY_GAIN;
  logic [STEPS_W-1:0]      ramp_len  = RAMP_STEPS_RST;
  logic [ALPHA_W-1:0]      rms_alpha = ALPHA_RST;
  logic                    invert_on = 1'b0;
  logic                    bypass_on = 1'b0;
  logic [GAIN_W-1:0]       live_gain = UNITY_GAIN;
  logic signed [INC_W-1:0] gain_step = '0;
  logic [STEPS_W-1:0]      ramp_left = '0;
  logic [SW-1:0]           peak_mag [IN_CH] = '{default: '0};
  logic [MS_W-1:0]         msq_avg  [IN_CH] = '{default: '0};

  meter_frame_t expected_frames[$];

  int unsigned mismatches     = 0;
  int unsigned frames_sent    = 0;
  int unsigned frames_checked = 0;
  int unsigned reg_writes     = 0;
  int unsigned in_gap_max     = 0;
  int unsigned out_gap_max    = 0;
  int unsigned hold_request   = 0;

  gain_ramp_peak_rms_meter u_top (.*);

  // 250 MHz clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor

  function automatic void track_reg_write(input logic [CFG_IDX_W-1:0]  idx,
                                          input logic [CFG_DATA_W-1:0] data);
    longint diff;
    longint span;
    case (idx)
      REG_GAIN_TARGET: begin
        // same value again leaves the ramp untouched
        if (data[GAIN_W-1:0] != gain_tgt) begin
          gain_tgt = data[GAIN_W-1:0];
          if (ramp_len == 0) begin
            live_gain = gain_tgt;
            gain_step = '0;
            ramp_left = '0;
          end else begin
            diff      = longint'(gain_tgt) - longint'(live_gain);
            span      = ((diff < 0) ? -diff : diff) / longint'(ramp_len);
            gain_step = INC_W'((diff < 0) ? -span : span);
            ramp_left = ramp_len;
          end
        end
      end
      REG_RAMP_STEPS:   ramp_len  = data[STEPS_W-1:0];
      REG_ALPHA_RMS:    rms_alpha = data[ALPHA_W-1:0];
      REG_PHASE_INVERT: invert_on = data[0];
      REG_BYPASS:       bypass_on = data[0];
      default: ;
    endcase
  endfunction

  function automatic meter_frame_t predict_frame(input logic [SW-1:0] left,
                                                 input logic [SW-1:0] right,
                                                 input logic          start);
    meter_frame_t f;
    logic [SW-1:0] lane_in  [IN_CH];
    logic [SW-1:0] lane_out [IN_CH];
    longint        stepped;
    longint        applied;
    longint        s;
    longint        y;
    logic [63:0]   mag;
    logic [63:0]   sq;
    logic [63:0]   acc;
    lane_in[0] = left;
    lane_in[1] = right;
    if (start) begin
      peak_mag[0] = '0;
      peak_mag[1] = '0;
    end
    // ramp steps once per frame, lands exactly on the target, holds in bypass
    if (!bypass_on && ramp_left != 0) begin
      ramp_left = ramp_left - 1'b1;
      if (ramp_left != 0) begin
        stepped = longint'(live_gain) + longint'(gain_step);
        if (stepped < 0) stepped = 0;
        if (stepped > longint'(GAIN_MAX)) stepped = longint'(GAIN_MAX);
        live_gain = stepped[GAIN_W-1:0];
      end else begin
        live_gain = gain_tgt;
      end
    end
    applied = invert_on ? -longint'(live_gain) : longint'(live_gain);
    for (int c = 0; c < IN_CH; c++) begin
      s = longint'(signed'(lane_in[c]));
      if (bypass_on) begin
        y = s;
      end else begin
        // round half up, then saturate to the sample width
        y = (s * applied + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        if (y > longint'(FS_POS)) y = longint'(FS_POS);
        if (y < -longint'(FS_NEG)) y = -longint'(FS_NEG);
      end
      mag = (y < 0) ? -y : y;
      if (mag > peak_mag[c]) peak_mag[c] = mag[SW-1:0];
      // square in Q0.32, full-scale negative clips to all ones
      sq = (mag * mag) >> SQ_SHIFT;
      if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
      acc = 64'(rms_alpha) * 64'(msq_avg[c])
          + ((64'd1 << ALPHA_W) - 64'(rms_alpha)) * sq;
      msq_avg[c]  = acc[MS_W+ALPHA_W-1:ALPHA_W];
      lane_out[c] = y[SW-1:0];
    end
    f.left_out   = lane_out[0];
    f.right_out  = lane_out[1];
    f.left_peak  = peak_mag[0];
    f.right_peak = peak_mag[1];
    f.left_msq   = msq_avg[0];
    f.right_msq  = msq_avg[1];
    return f;
  endfunction

  // ---------------------------------------------------------------------------
  // driving and checking

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("%0t ns mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [MS_W-1:0] got,
                             input logic [MS_W-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("frame %0d %s got %h want %h",
                                frames_checked, name, got, want));
    end
  endtask

  // register write, only issued with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    track_reg_write(idx, data);
    reg_writes++;
  endtask

  // one input beat; valid stays up into the next frame when no gap is drawn
  task automatic send_frame(input logic [SW-1:0] left, input logic [SW-1:0] right,
                            input logic start);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_left_i  <= left;
    sample_right_i <= right;
    block_start_i  <= start;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    expected_frames.push_back(predict_frame(left, right, start));
    frames_sent++;
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
  endtask

  // mostly full random, with extremes and small magnitudes mixed in
  function automatic logic [SW-1:0] pick_sample();
    logic [SW-1:0] v;
    v = SW'($urandom);
    case ($urandom_range(0, 7))
      0: v = FS_NEG;
      1: v = FS_POS;
      2: v = {{(SW-8){v[7]}}, v[7:0]};
      default: ;
    endcase
    return v;
  endfunction

  // output ready: random gaps per beat, or one long hold-off on request
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_request != 0) begin
        gap          = hold_request;
        hold_request = 0;
      end else begin
        gap = $urandom_range(0, out_gap_max);
      end
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  // compare each result beat against the oldest prediction
  always @(posedge clk_i) begin : result_check
    meter_frame_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_frames.size() == 0) begin
        report_mismatch("result beat with no frame outstanding");
      end else begin
        want = expected_frames.pop_front();
        check_field("out_left", {8'h00, out_left_o}, {8'h00, want.left_out});
        check_field("out_right", {8'h00, out_right_o}, {8'h00, want.right_out});
        check_field("peak_left", {8'h00, peak_left_o}, {8'h00, want.left_peak});
        check_field("peak_right", {8'h00, peak_right_o}, {8'h00, want.right_peak});
        check_field("mean_square_left", mean_square_left_o, want.left_msq);
        check_field("mean_square_right", mean_square_right_o, want.right_msq);
        frames_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests

  // default unity gain: full-scale samples, peak clear and square clipping
  task automatic test_unity_extremes();
    in_gap_max  = 0;
    out_gap_max = 0;
    send_frame(FS_POS, FS_NEG, 1'b0);
    send_frame(FS_NEG, FS_POS, 1'b1);
    send_frame('0, '1, 1'b0);
    send_frame(24'h000001, 24'h400000, 1'b1);
    settle();
  endtask

  task automatic test_gain_ramp();
    in_gap_max  = 3;
    out_gap_max = 3;
    // short ramp up to twice unity
    write_reg(REG_RAMP_STEPS, 24'd4);
    write_reg(REG_GAIN_TARGET, UNITY_GAIN << 1);
    repeat (5) send_frame(pick_sample(), pick_sample(), 1'b0);
    settle();
    // same target again leaves the gain alone
    write_reg(REG_GAIN_TARGET, UNITY_GAIN << 1);
    send_frame(FS_POS, FS_NEG, 1'b0);
    settle();
    // a new ramp length mid-ramp only counts for the next target
    write_reg(REG_RAMP_STEPS, 24'd3);
    write_reg(REG_GAIN_TARGET, UNITY_GAIN >> 1);
    send_frame(pick_sample(), pick_sample(), 1'b1);
    settle();
    write_reg(REG_RAMP_STEPS, 24'd7);
    repeat (3) send_frame(pick_sample(), pick_sample(), 1'b0);
    settle();
    // zero ramp length jumps straight to the largest gain
    write_reg(REG_RAMP_STEPS, '0);
    write_reg(REG_GAIN_TARGET, GAIN_MAX);
    send_frame(FS_NEG, 24'h000003, 1'b1);
    send_frame(FS_POS, 24'hFFFFFD, 1'b0);
    settle();
    // longest ramp down to zero, junk above the ramp field
    write_reg(REG_RAMP_STEPS, 24'hABFFFF);
    write_reg(REG_GAIN_TARGET, '0);
    repeat (2) send_frame(pick_sample(), pick_sample(), 1'b0);
    settle();
  endtask

  task automatic test_invert_bypass();
    in_gap_max  = 2;
    out_gap_max = 2;
    // inverted gain while ramping, negated full scale saturates
    write_reg(REG_RAMP_STEPS, 24'd8);
    write_reg(REG_PHASE_INVERT, 24'd1);
    write_reg(REG_GAIN_TARGET, 24'h180000);
    send_frame(FS_NEG, FS_POS, 1'b1);
    send_frame(pick_sample(), pick_sample(), 1'b0);
    settle();
    // bypass passes samples through and freezes the ramp
    write_reg(REG_BYPASS, 24'd1);
    send_frame(FS_NEG, FS_POS, 1'b0);
    send_frame(pick_sample(), pick_sample(), 1'b1);
    settle();
    // averaging extremes: no memory, then nearly all memory
    write_reg(REG_BYPASS, '0);
    write_reg(REG_PHASE_INVERT, '0);
    write_reg(REG_ALPHA_RMS, '0);
    send_frame(FS_POS, FS_NEG, 1'b0);
    settle();
    write_reg(REG_ALPHA_RMS, 24'hFFFFFF);
    write_reg(REG_SPARE_FIRST, 24'h5A5A5A);
    send_frame(pick_sample(), pick_sample(), 1'b0);
    settle();
  endtask

  // sink stalls for a long stretch while frames keep coming
  task automatic test_output_stall();
    in_gap_max   = 0;
    out_gap_max  = 0;
    hold_request = 400;
    repeat (40) send_frame(pick_sample(), pick_sample(), $urandom_range(0, 15) == 0);
    settle();
  endtask

  // random register settings per phase, random frames in between
  task automatic test_random_settings(input int unsigned phases,
                                      input int unsigned frames_per_phase);
    logic [CFG_DATA_W-1:0] d;
    for (int unsigned ph = 0; ph < phases; ph++) begin
      in_gap_max  = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
      // ramp length, mostly short so ramps finish inside a phase
      d = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 7))
        0: d[STEPS_W-1:0] = '0;
        1: d[STEPS_W-1:0] = 14'd1;
        2: d[STEPS_W-1:0] = '1;
        default: d[STEPS_W-1:0] = 14'($urandom_range(2, 80));
      endcase
      if ($urandom_range(0, 3) != 0) write_reg(REG_RAMP_STEPS, d);
      d = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 5))
        0: d[ALPHA_W-1:0] = '0;
        1: d[ALPHA_W-1:0] = '1;
        2: d[ALPHA_W-1:0] = ALPHA_RST;
        default: ;
      endcase
      if ($urandom_range(0, 2) != 0) write_reg(REG_ALPHA_RMS, d);
      if ($urandom_range(0, 1) != 0) write_reg(REG_PHASE_INVERT, CFG_DATA_W'($urandom));
      d    = CFG_DATA_W'($urandom);
      d[0] = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) != 0) write_reg(REG_BYPASS, d);
      if ($urandom_range(0, 5) == 0) begin
        write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                  CFG_DATA_W'($urandom));
      end
      // target last, since it starts the step divide
      d = CFG_DATA_W'($urandom);
      case ($urandom_range(0, 7))
        0: d = '0;
        1: d = GAIN_MAX;
        2, 3: d = gain_tgt;
        4, 5: d = CFG_DATA_W'($urandom_range(UNITY_GAIN >> 2, UNITY_GAIN << 1));
        default: ;
      endcase
      write_reg(REG_GAIN_TARGET, d);
      for (int unsigned n = 0; n < frames_per_phase; n++) begin
        send_frame(pick_sample(), pick_sample(), $urandom_range(0, 15) == 0);
      end
      settle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence

  initial begin : run
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_unity_extremes();
    test_gain_ramp();
    test_invert_bypass();
    test_output_stall();
    test_random_settings(10, 100);
    repeat (16) @(posedge clk_i);
    $display("frames: %0d sent, %0d checked; register writes: %0d; mismatches: %0d",
             frames_sent, frames_checked, reg_writes, mismatches);
    $display("covered ramps, target jumps, inversion, bypass, meter extremes, sink stall");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // hang guard, well above the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ gain_ramp_peak_rms_meter.f @@
src/grpm_pkg.sv
src/grpm_div.sv
src/grpm_lane.sv
src/gain_ramp_peak_rms_meter.sv
src/grpm_checker.sv
dv/gain_ramp_peak_rms_meter_test.sv
